FILE: src/tss_pkg.sv
// shared types and constants for the text substring search unit
// no dependencies; imported by every module of the block
package tss_pkg;

   localparam int unsigned MAX_PATTERN_DEF = 32;
   localparam int unsigned MAX_TEXT_DEF = 65536;

   localparam int unsigned LEN_W = 6;
   localparam int unsigned CURSOR_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 64;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LO = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MID_LO = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MID_HI = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HI = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_CASE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_BACKWARD = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_POSITION = 3'd7;

   // ascii bounds for case folding
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [CURSOR_W-1:0] match_start;
   } rsp_type;

   // control shared by every cell of the window row
   typedef struct packed {
      logic             shift;
      logic             ignore_case;
      logic [LEN_W-1:0] pattern_length;
   } cell_ctrl_type;

endpackage

FILE: src/text_substring_search_unit.sv
// top level of the streaming substring search unit
// depends on tss_pkg and tss_cell
//
// Text bytes enter one per clock on the request channel, oldest first, and
// march down a row of MAX_PATTERN cells. Each cell compares the byte it takes
// in against the pattern byte that lines up with it, so the full window check
// is ready in the cycle after a byte is accepted. The sustained rate is one
// text byte per clock while the input is not stalled. The single response of
// a text (found flag and start index) shows up on rsp after the request
// carrying last_byte has passed the cell row and then the output register.
// The input stalls only when a last byte sits at the compare stage while the
// previous response is still held by a stalled rsp channel. Register writes
// land in the next cycle, csr_ready is always high; write them between texts.
module text_substring_search_unit #(
   parameter int unsigned MAX_PATTERN = tss_pkg::MAX_PATTERN_DEF,
   parameter int unsigned MAX_TEXT = tss_pkg::MAX_TEXT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tss_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tss_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tss_pkg::*;

   // byte index saturates at MAX_TEXT + MAX_PATTERN
   localparam int unsigned IDX_LIMIT = MAX_TEXT + MAX_PATTERN;
   localparam int unsigned IDX_W = $clog2(IDX_LIMIT + 1);
   localparam int unsigned CALC_W = (IDX_W + 1 > CURSOR_W) ? IDX_W + 1 : CURSOR_W;
   // starts at or above this are out of range
   localparam int unsigned START_LIMIT = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;

   // configuration registers
   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in;
   logic [CSR_DATA_W-1:0] pat_mlo_ff, pat_mlo_in;
   logic [CSR_DATA_W-1:0] pat_mhi_ff, pat_mhi_in;
   logic [CSR_DATA_W-1:0] pat_hi_ff, pat_hi_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  icase_ff, icase_in;
   logic                  backward_ff, backward_in;
   logic [CURSOR_W-1:0]   cursor_ff, cursor_in;

   // per-text state
   logic [IDX_W-1:0]      byte_index_ff, byte_index_in;
   logic                  have_ff, have_in;
   logic [CURSOR_W-1:0]   best_ff, best_in;

   // compare stage bookkeeping, aligned with the cell row
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  s1_cand_ff, s1_cand_in;
   logic [CURSOR_W-1:0]   s1_start_ff, s1_start_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  s1_block;
   logic                  accept;
   logic                  retire;
   logic                  hit;
   logic                  len_ok;
   logic                  in_range;
   logic                  reach_ok;
   logic                  start_ok;
   logic [CALC_W-1:0]     next_ext;
   logic [CALC_W-1:0]     len_ext;
   logic [CALC_W-1:0]     start_ext;
   logic                  found_nx;
   logic [CURSOR_W-1:0]   best_nx;

   logic [4*CSR_DATA_W-1:0] pattern_all;
   cell_ctrl_type           cell_ctrl;
   logic [7:0]              chain [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]  cell_hit;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------------
   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_mlo_in = pat_mlo_ff;
      pat_mhi_in = pat_mhi_ff;
      pat_hi_in = pat_hi_ff;
      len_in = len_ff;
      icase_in = icase_ff;
      backward_in = backward_ff;
      cursor_in = cursor_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LO:      pat_lo_in = csr_data;
            CSR_PATTERN_MID_LO:  pat_mlo_in = csr_data;
            CSR_PATTERN_MID_HI:  pat_mhi_in = csr_data;
            CSR_PATTERN_HI:      pat_hi_in = csr_data;
            CSR_PATTERN_LENGTH:  len_in = csr_data[LEN_W-1:0];
            CSR_IGNORE_CASE:     icase_in = csr_data[0];
            CSR_SEARCH_BACKWARD: backward_in = csr_data[0];
            CSR_CURSOR_POSITION: cursor_in = csr_data[CURSOR_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // flow control: only a last byte waiting on a full output holds things
   // ---------------------------------------------------------------------
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      s1_block = s1_valid_ff && s1_last_ff && !out_free;
      accept = req_valid && !s1_block;
      retire = s1_valid_ff && !s1_block;
   end

   assign req_stall = s1_block;

   // ---------------------------------------------------------------------
   // window cell row: cell w holds the byte w positions back
   // ---------------------------------------------------------------------
   assign pattern_all = {pat_hi_ff, pat_mhi_ff, pat_mlo_ff, pat_lo_ff};
   assign chain[0] = req_data.text_byte;

   always_comb begin
      cell_ctrl.shift = accept;
      cell_ctrl.ignore_case = icase_ff;
      cell_ctrl.pattern_length = len_ff;
   end

   for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_cell
      tss_cell #(
         .CELL_INDEX  (w),
         .MAX_PATTERN (MAX_PATTERN)
      ) u_cell (
         .clock         (clock),
         .ctrl          (cell_ctrl),
         .pattern_bytes (pattern_all[MAX_PATTERN*8-1:0]),
         .shift_in      (chain[w]),
         .shift_out     (chain[w+1]),
         .match_out     (cell_hit[w])
      );
   end

   // ---------------------------------------------------------------------
   // position checks for the byte being accepted
   // ---------------------------------------------------------------------
   always_comb begin
      len_ok = (len_ff != '0) && (len_ff <= LEN_W'(MAX_PATTERN));
      in_range = byte_index_ff < IDX_W'(IDX_LIMIT);
      next_ext = CALC_W'(byte_index_ff) + CALC_W'(1);
      len_ext = CALC_W'(len_ff);
      // match must lie wholly inside the text
      reach_ok = next_ext >= len_ext;
      start_ext = next_ext - len_ext;
      start_ok = start_ext < CALC_W'(START_LIMIT);

      s1_valid_in = s1_block ? s1_valid_ff : accept;
      s1_last_in = s1_block ? s1_last_ff : req_data.last_byte;
      s1_cand_in = s1_block ? s1_cand_ff : (in_range && reach_ok && len_ok && start_ok);
      s1_start_in = s1_block ? s1_start_ff : start_ext[CURSOR_W-1:0];

      byte_index_in = byte_index_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            byte_index_in = '0;
         end else if (in_range) begin
            byte_index_in = byte_index_ff + IDX_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // match selection and response
   // ---------------------------------------------------------------------
   always_comb begin
      hit = s1_cand_ff && (&cell_hit);
      found_nx = have_ff;
      best_nx = best_ff;
      if (hit) begin
         if (!backward_ff) begin
            // forward keeps the first match at or after the cursor
            if (!have_ff && s1_start_ff >= cursor_ff) begin
               found_nx = 1'b1;
               best_nx = s1_start_ff;
            end
         end else if (s1_start_ff < cursor_ff) begin
            // backward keeps the latest match before the cursor
            found_nx = 1'b1;
            best_nx = s1_start_ff;
         end
      end

      have_in = have_ff;
      best_in = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (retire) begin
         if (s1_last_ff) begin
            have_in = 1'b0;
            best_in = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in.found = found_nx;
            rsp_data_in.match_start = found_nx ? best_nx : '0;
         end else begin
            have_in = found_nx;
            best_in = best_nx;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_mlo_ff <= '0;
         pat_mhi_ff <= '0;
         pat_hi_ff <= '0;
         len_ff <= '0;
         icase_ff <= 1'b0;
         backward_ff <= 1'b0;
         cursor_ff <= '0;
         byte_index_ff <= '0;
         have_ff <= 1'b0;
         best_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_lo_ff <= pat_lo_in;
         pat_mlo_ff <= pat_mlo_in;
         pat_mhi_ff <= pat_mhi_in;
         pat_hi_ff <= pat_hi_in;
         len_ff <= len_in;
         icase_ff <= icase_in;
         backward_ff <= backward_in;
         cursor_ff <= cursor_in;
         byte_index_ff <= byte_index_in;
         have_ff <= have_in;
         best_ff <= best_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      s1_cand_ff <= s1_cand_in;
      s1_start_ff <= s1_start_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: src/tss_cell.sv
// one window cell: holds one recent text byte and its compare result
// depends on tss_pkg
module tss_cell #(
   parameter int unsigned CELL_INDEX = 0,
   parameter int unsigned MAX_PATTERN = tss_pkg::MAX_PATTERN_DEF
) (
   input  logic                       clock,
   input  tss_pkg::cell_ctrl_type     ctrl,
   input  logic [MAX_PATTERN*8-1:0]   pattern_bytes,
   input  logic [7:0]                 shift_in,
   output logic [7:0]                 shift_out,
   output logic                       match_out
);
   import tss_pkg::*;

   localparam int unsigned SEL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]       held_ff, held_in;
   logic             hit_ff, hit_in;
   logic             cmp_en;
   logic [LEN_W-1:0] sel_full;
   logic [SEL_W-1:0] sel;
   logic [7:0]       pat;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         r = c + (ASCII_LOWER_A - ASCII_UPPER_A);
      end
      return r;
   endfunction

   // this cell lines up with pattern byte length-1-index
   always_comb begin
      cmp_en = LEN_W'(CELL_INDEX) < ctrl.pattern_length;
      sel_full = ctrl.pattern_length - LEN_W'(CELL_INDEX) - LEN_W'(1);
      sel = sel_full[SEL_W-1:0];
      pat = pattern_bytes[sel*8 +: 8];
      held_in = ctrl.shift ? shift_in : held_ff;
      hit_in = ctrl.shift
         ? (!cmp_en || fold(shift_in, ctrl.ignore_case) == fold(pat, ctrl.ignore_case))
         : hit_ff;
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      hit_ff <= hit_in;
   end

   assign shift_out = held_ff;
   assign match_out = hit_ff;

endmodule

FILE: src/tss_checker.sv
// port-level checks for the text substring search unit, bound to the top
// depends on tss_pkg and text_substring_search_unit
module tss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input tss_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input tss_pkg::rsp_type               rsp_data
);
   import tss_pkg::*;

   // a miss always reports start zero
   a_miss_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_start == '0)
      else $error("response without match carries nonzero start");

   // a new response must be preceded by an accepted last-byte request
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.last_byte, 2))
      else $error("response without a preceding last byte");

   // the input only stalls behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the output free");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind text_substring_search_unit tss_checker u_tss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
